// ===== hw/rtl/chi_pkg.sv =====
// Shared types and constants for the chained hash table block.
// Used by the interfaces and by every module under hw/rtl but chi_ram; depends on nothing else.
`timescale 1ns / 1ps

package chi_pkg;

  // Table geometry
  localparam int MAX_BUCKETS = 256;
  localparam int POOL_DEPTH  = 64;
  localparam int RESULT_CAP  = 64;
  localparam int LIMIT_MAX   = (POOL_DEPTH < RESULT_CAP) ? POOL_DEPTH : RESULT_CAP;

  // Field and register widths
  localparam int CMD_W   = 2;
  localparam int VALUE_W = 31;
  localparam int SEL_W   = 8;
  localparam int BCNT_W  = 9;
  localparam int CAP_W   = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam int BKT_AW   = $clog2(MAX_BUCKETS);
  localparam int NODE_AW  = $clog2(POOL_DEPTH);
  localparam int CNT_W    = $clog2(POOL_DEPTH + 1);
  localparam int DIV_CNT_W = $clog2(VALUE_W);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY     = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_BKT_RD,
    S_LINK,
    S_FIX,
    S_EMPTY,
    S_HEAD,
    S_EMIT
  } chi_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic latch_item;
    logic div_start;
    logic clear_tbl;
    logic bkt_rd_key;
    logic bkt_rd_sel;
    logic link;
    logic fix;
    logic cnt_inc;
    logic node_rd_head;
    logic node_rd_next;
    logic load_empty;
    logic load_entry;
  } chi_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             insert_ok;
    logic             sel_valid;
    logic             key_valid;
    logic             div_done;
    logic             out_free;
    logic             chain_end;
  } chi_sts_t;

endpackage

// ===== hw/rtl/chi_if.sv =====
// Channel interfaces: command input, result output and register write port.
// Depends on chi_pkg for field widths.
`timescale 1ns / 1ps

interface chi_in_if;
  logic                         valid;
  logic                         ready;
  logic [chi_pkg::CMD_W-1:0]    cmd;
  logic [chi_pkg::VALUE_W-1:0]  value;
  logic [chi_pkg::SEL_W-1:0]    bucket_sel;

  modport source (output valid, cmd, value, bucket_sel, input ready);
  modport sink   (input valid, cmd, value, bucket_sel, output ready);
endinterface

interface chi_out_if;
  logic                         valid;
  logic                         ready;
  logic [chi_pkg::SEL_W-1:0]    bucket_out;
  logic [chi_pkg::VALUE_W-1:0]  entry_value;
  logic                         empty_res;
  logic                         last;

  modport source (output valid, bucket_out, entry_value, empty_res, last, input ready);
  modport sink   (input valid, bucket_out, entry_value, empty_res, last, output ready);
endinterface

interface chi_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [chi_pkg::CFG_IDX_W-1:0]   index;
  logic [chi_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/chained_hash_insert_dump.sv =====
// Top level of the chained hash table: controller plus datapath.
// Depends on chi_pkg, chi_if, chi_ctrl and chi_dp.
`timescale 1ns / 1ps

// Chained hash table over a 64-node pool and 256 buckets. One command beat is
// taken at a time, and only while the controller is idle; a waiting result in
// the output register does not block acceptance. An insert holds the
// controller through the decode state, the bit-serial remainder of the value
// by the bucket count, the hand-over of the remainder with the bucket RAM
// read, the read data and the link write; it also links the old tail when
// the bucket already held entries. A read of an empty bucket gives its single
// beat; a read of a filled bucket gives its first beat and one more per cycle
// while the sink keeps ready high, since each beat is one node RAM read. An
// insert dropped at the fill limit, a clear and an unknown command go back to
// idle straight after decode. Bucket occupancy sits in per-bucket flops that
// reset and clear empty at once, so no clearing pass runs after reset.
// The user must write registers through the configuration port only while
// idle; the block itself does not enforce this.
module chained_hash_insert_dump (
  input  logic      clk_i,
  input  logic      rst_ni,
  chi_in_if.sink    in_i,
  chi_out_if.source out_o,
  chi_cfg_if.sink   cfg_i
);

  chi_pkg::chi_ctl_t ctl;
  chi_pkg::chi_sts_t sts;
  logic              in_ready;

  assign in_i.ready = in_ready;

  chi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  chi_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .cmd_i        (in_i.cmd),
    .value_i      (in_i.value),
    .bucket_sel_i (in_i.bucket_sel),
    .out_o        (out_o),
    .cfg_i        (cfg_i)
  );

endmodule

// ===== hw/rtl/chi_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module chi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                           wr_data_i,
  input  logic                                       rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                           rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, hold data between reads
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/chi_mod.sv =====
// Bit-serial remainder unit: dividend modulo divisor, one dividend bit per cycle.
// Depends on chi_pkg for widths.
`timescale 1ns / 1ps

module chi_mod (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [chi_pkg::VALUE_W-1:0]   dividend_i,
  input  logic [chi_pkg::BCNT_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [chi_pkg::BCNT_W-1:0]    rem_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [chi_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [chi_pkg::VALUE_W-1:0]     dvd_q, dvd_d;
  logic [chi_pkg::BCNT_W-1:0]      rem_q, rem_d;
  logic [chi_pkg::BCNT_W-1:0]      dsr_q, dsr_d;
  logic [chi_pkg::BCNT_W:0]        trial;
  logic [chi_pkg::BCNT_W:0]        trial_sub;

  // Shift in the next dividend bit and subtract when it fits
  assign trial     = {rem_q, dvd_q[chi_pkg::VALUE_W-1]};
  assign trial_sub = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      dvd_d = {dvd_q[chi_pkg::VALUE_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = trial_sub[chi_pkg::BCNT_W-1:0];
      end else begin
        rem_d = trial[chi_pkg::BCNT_W-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == chi_pkg::DIV_CNT_W'(chi_pkg::VALUE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand flops
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== hw/rtl/chi_dp.sv =====
// Datapath: config registers, item latch, remainder unit, bucket and node RAMs,
// bucket valid bits, entry count and the result register. Depends on chi_pkg,
// chi_if, chi_ram and chi_mod.
`timescale 1ns / 1ps

module chi_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  chi_pkg::chi_ctl_t             ctl_i,
  output chi_pkg::chi_sts_t             sts_o,
  input  logic [chi_pkg::CMD_W-1:0]     cmd_i,
  input  logic [chi_pkg::VALUE_W-1:0]   value_i,
  input  logic [chi_pkg::SEL_W-1:0]     bucket_sel_i,
  chi_out_if.source                     out_o,
  chi_cfg_if.sink                       cfg_i
);

  localparam int BKT_W = 2 * chi_pkg::NODE_AW;

  // Config registers
  logic [chi_pkg::BCNT_W-1:0] bucket_count_q;
  logic [chi_pkg::CAP_W-1:0]  capacity_q;
  logic [chi_pkg::BCNT_W-1:0] eff_buckets;
  logic [chi_pkg::CNT_W-1:0]  eff_limit;

  // Item latch
  logic [chi_pkg::CMD_W-1:0]   cmd_q;
  logic [chi_pkg::VALUE_W-1:0] value_q;
  logic [chi_pkg::SEL_W-1:0]   sel_q;

  // Table state
  logic [chi_pkg::MAX_BUCKETS-1:0] bkt_valid_q;
  logic [chi_pkg::CNT_W-1:0]       count_q;
  logic [chi_pkg::NODE_AW-1:0]     slot;

  // Walk state
  logic [chi_pkg::NODE_AW-1:0] node_q;
  logic [chi_pkg::NODE_AW-1:0] tail_q;
  logic [chi_pkg::CNT_W-1:0]   steps_q;

  // Remainder unit
  logic                        div_done;
  logic [chi_pkg::BCNT_W-1:0]  rem;
  logic [chi_pkg::BKT_AW-1:0]  key;

  // RAM ports
  logic                        bkt_we;
  logic [BKT_W-1:0]            bkt_wdata;
  logic                        bkt_re;
  logic [chi_pkg::BKT_AW-1:0]  bkt_raddr;
  logic [BKT_W-1:0]            bkt_rdata;
  logic [chi_pkg::NODE_AW-1:0] head_rd;
  logic [chi_pkg::NODE_AW-1:0] tail_rd;

  logic                        next_we;
  logic [chi_pkg::NODE_AW-1:0] next_waddr;
  logic [chi_pkg::NODE_AW-1:0] next_wdata;
  logic                        node_re;
  logic [chi_pkg::NODE_AW-1:0] node_raddr;
  logic [chi_pkg::NODE_AW-1:0] next_rd;
  logic [chi_pkg::VALUE_W-1:0] value_rd;

  // Result register
  logic                        out_valid_q;
  logic [chi_pkg::SEL_W-1:0]   out_bucket_q;
  logic [chi_pkg::VALUE_W-1:0] out_value_q;
  logic                        out_empty_q;
  logic                        out_last_q;
  logic                        out_free;
  logic                        chain_end;

  // Config write port, always ready; unknown indexes are ignored
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= chi_pkg::BCNT_W'(1);
      capacity_q     <= chi_pkg::CAP_W'(64);
    end else if (cfg_i.valid) begin
      if (cfg_i.index == chi_pkg::REG_BUCKET_COUNT) begin
        bucket_count_q <= cfg_i.data[chi_pkg::BCNT_W-1:0];
      end else if (cfg_i.index == chi_pkg::REG_CAPACITY) begin
        capacity_q <= cfg_i.data[chi_pkg::CAP_W-1:0];
      end
    end
  end

  // Effective divisor and fill limit
  always_comb begin
    if (bucket_count_q == '0) begin
      eff_buckets = chi_pkg::BCNT_W'(1);
    end else if (bucket_count_q > chi_pkg::BCNT_W'(chi_pkg::MAX_BUCKETS)) begin
      eff_buckets = chi_pkg::BCNT_W'(chi_pkg::MAX_BUCKETS);
    end else begin
      eff_buckets = bucket_count_q;
    end
    if (capacity_q > chi_pkg::CAP_W'(chi_pkg::LIMIT_MAX)) begin
      eff_limit = chi_pkg::CNT_W'(chi_pkg::LIMIT_MAX);
    end else begin
      eff_limit = chi_pkg::CNT_W'(capacity_q);
    end
  end

  // Capture the accepted beat
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch_item) begin
      cmd_q   <= cmd_i;
      value_q <= value_i;
      sel_q   <= bucket_sel_i;
    end
  end

  chi_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl_i.div_start),
    .dividend_i (value_q),
    .divisor_i  (eff_buckets),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  // Remainder is below the bucket count, so it fits the bucket index
  assign key  = rem[chi_pkg::BKT_AW-1:0];
  assign slot = count_q[chi_pkg::NODE_AW-1:0];

  // Bucket valid bits and entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bkt_valid_q <= '0;
      count_q     <= '0;
    end else if (ctl_i.clear_tbl) begin
      bkt_valid_q <= '0;
      count_q     <= '0;
    end else begin
      if (ctl_i.link) begin
        bkt_valid_q[key] <= 1'b1;
      end
      if (ctl_i.cnt_inc) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  // Bucket RAM holds {head, tail} per bucket
  assign head_rd   = bkt_rdata[BKT_W-1:chi_pkg::NODE_AW];
  assign tail_rd   = bkt_rdata[chi_pkg::NODE_AW-1:0];
  assign bkt_we    = ctl_i.link;
  assign bkt_wdata = bkt_valid_q[key] ? {head_rd, slot} : {slot, slot};
  assign bkt_re    = ctl_i.bkt_rd_key | ctl_i.bkt_rd_sel;
  assign bkt_raddr = ctl_i.bkt_rd_sel ? chi_pkg::BKT_AW'(sel_q) : key;

  chi_ram #(
    .WIDTH (BKT_W),
    .DEPTH (chi_pkg::MAX_BUCKETS)
  ) u_bkt_ram (
    .clk_i     (clk_i),
    .wr_en_i   (bkt_we),
    .wr_addr_i (key),
    .wr_data_i (bkt_wdata),
    .rd_en_i   (bkt_re),
    .rd_addr_i (bkt_raddr),
    .rd_data_o (bkt_rdata)
  );

  // Node RAMs: new node gets a null link, then the old tail links to it
  assign next_we    = ctl_i.link | ctl_i.fix;
  assign next_waddr = ctl_i.fix ? tail_q : slot;
  assign next_wdata = ctl_i.fix ? slot : '0;
  assign node_re    = ctl_i.node_rd_head | ctl_i.node_rd_next;
  assign node_raddr = ctl_i.node_rd_head ? head_rd : next_rd;

  chi_ram #(
    .WIDTH (chi_pkg::NODE_AW),
    .DEPTH (chi_pkg::POOL_DEPTH)
  ) u_next_ram (
    .clk_i     (clk_i),
    .wr_en_i   (next_we),
    .wr_addr_i (next_waddr),
    .wr_data_i (next_wdata),
    .rd_en_i   (node_re),
    .rd_addr_i (node_raddr),
    .rd_data_o (next_rd)
  );

  chi_ram #(
    .WIDTH (chi_pkg::VALUE_W),
    .DEPTH (chi_pkg::POOL_DEPTH)
  ) u_value_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ctl_i.link),
    .wr_addr_i (slot),
    .wr_data_i (value_q),
    .rd_en_i   (node_re),
    .rd_addr_i (node_raddr),
    .rd_data_o (value_rd)
  );

  // Track the walk: current node, chain tail and step count
  always_ff @(posedge clk_i) begin
    if (ctl_i.node_rd_head) begin
      node_q  <= head_rd;
      tail_q  <= tail_rd;
      steps_q <= chi_pkg::CNT_W'(1);
    end else if (ctl_i.node_rd_next) begin
      node_q  <= next_rd;
      steps_q <= steps_q + 1'b1;
    end else if (ctl_i.link) begin
      tail_q  <= tail_rd;
    end
  end

  assign chain_end = (node_q == tail_q) || (steps_q >= count_q) ||
                     (steps_q >= chi_pkg::CNT_W'(chi_pkg::RESULT_CAP));

  // Result register
  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.load_empty || ctl_i.load_entry) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_empty) begin
      out_bucket_q <= sel_q;
      out_value_q  <= '0;
      out_empty_q  <= 1'b1;
      out_last_q   <= 1'b1;
    end else if (ctl_i.load_entry) begin
      out_bucket_q <= sel_q;
      out_value_q  <= value_rd;
      out_empty_q  <= 1'b0;
      out_last_q   <= chain_end;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.bucket_out  = out_bucket_q;
  assign out_o.entry_value = out_value_q;
  assign out_o.empty_res   = out_empty_q;
  assign out_o.last        = out_last_q;

  // Status back to the controller
  assign sts_o.cmd       = cmd_q;
  assign sts_o.insert_ok = count_q < eff_limit;
  assign sts_o.sel_valid = bkt_valid_q[chi_pkg::BKT_AW'(sel_q)];
  assign sts_o.key_valid = bkt_valid_q[key];
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = out_free;
  assign sts_o.chain_end = chain_end;

endmodule

// ===== hw/rtl/chi_ctrl.sv =====
// Controller state machine: sequences insert, read and clear over the datapath.
// Depends on chi_pkg for the state enum and the command/status structs.
`timescale 1ns / 1ps

module chi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  chi_pkg::chi_sts_t sts_i,
  output chi_pkg::chi_ctl_t ctl_o
);

  chi_pkg::chi_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chi_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      chi_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = chi_pkg::S_DECODE;
        end
      end
      chi_pkg::S_DECODE: begin
        priority if (sts_i.cmd == chi_pkg::CMD_INSERT) begin
          state_d = sts_i.insert_ok ? chi_pkg::S_DIV : chi_pkg::S_IDLE;
        end else if (sts_i.cmd == chi_pkg::CMD_READ) begin
          state_d = sts_i.sel_valid ? chi_pkg::S_HEAD : chi_pkg::S_EMPTY;
        end else begin
          state_d = chi_pkg::S_IDLE;
        end
      end
      chi_pkg::S_DIV: begin
        if (sts_i.div_done) begin
          state_d = chi_pkg::S_BKT_RD;
        end
      end
      chi_pkg::S_BKT_RD: state_d = chi_pkg::S_LINK;
      chi_pkg::S_LINK: begin
        state_d = sts_i.key_valid ? chi_pkg::S_FIX : chi_pkg::S_IDLE;
      end
      chi_pkg::S_FIX: state_d = chi_pkg::S_IDLE;
      chi_pkg::S_EMPTY: begin
        if (sts_i.out_free) begin
          state_d = chi_pkg::S_IDLE;
        end
      end
      chi_pkg::S_HEAD: state_d = chi_pkg::S_EMIT;
      chi_pkg::S_EMIT: begin
        if (sts_i.out_free && sts_i.chain_end) begin
          state_d = chi_pkg::S_IDLE;
        end
      end
      default: state_d = chi_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      chi_pkg::S_IDLE: begin
        in_ready_o       = 1'b1;
        ctl_o.latch_item = in_valid_i;
      end
      chi_pkg::S_DECODE: begin
        priority if (sts_i.cmd == chi_pkg::CMD_INSERT) begin
          ctl_o.div_start = sts_i.insert_ok;
        end else if (sts_i.cmd == chi_pkg::CMD_READ) begin
          ctl_o.bkt_rd_sel = sts_i.sel_valid;
        end else if (sts_i.cmd == chi_pkg::CMD_CLEAR) begin
          ctl_o.clear_tbl = 1'b1;
        end else begin
          ctl_o.clear_tbl = 1'b0;
        end
      end
      chi_pkg::S_DIV: begin
        ctl_o.bkt_rd_key = sts_i.div_done;
      end
      chi_pkg::S_BKT_RD: begin
        ctl_o = '0;
      end
      chi_pkg::S_LINK: begin
        ctl_o.link    = 1'b1;
        ctl_o.cnt_inc = !sts_i.key_valid;
      end
      chi_pkg::S_FIX: begin
        ctl_o.fix     = 1'b1;
        ctl_o.cnt_inc = 1'b1;
      end
      chi_pkg::S_EMPTY: begin
        ctl_o.load_empty = sts_i.out_free;
      end
      chi_pkg::S_HEAD: begin
        ctl_o.node_rd_head = 1'b1;
      end
      chi_pkg::S_EMIT: begin
        ctl_o.load_entry   = sts_i.out_free;
        ctl_o.node_rd_next = sts_i.out_free && !sts_i.chain_end;
      end
      default: ctl_o = '0;
    endcase
  end

endmodule
